FILE: hw/rtl/rlbd_pkg.sv
package rlbd_pkg;

  // Block configuration
  localparam int NUM_BITMAPS = 8;
  localparam int ADDR_BITS   = 24;

  // Field and register widths
  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 24;
  localparam int ROM_LEN_W   = 25;
  localparam int BMP_CNT_W   = 4;
  localparam int SRC_W       = ADDR_BITS + 1;
  localparam int END_ADDR_W  = 24;
  localparam int MASK_W      = 8;
  localparam int PEN_W       = 4;
  localparam int COORD_W     = 8;
  localparam int LEN_W       = 9;
  localparam int CUR_X_W     = 10;
  localparam int CUR_Y_W     = 9;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_COUNT = 1'd1;

  // Reset values of the configuration
  localparam logic [ROM_LEN_W-1:0] ROM_CAP     = ROM_LEN_W'(64'd1 << ADDR_BITS);
  localparam logic [MASK_W-1:0]    PRESENT_ALL = MASK_W'((64'd1 << NUM_BITMAPS) - 64'd1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Bus command codes
  localparam logic [CMD_W-1:0] CMD_SET_DEST   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LAYER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_SOURCE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROM_BYTE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  // Graphics ROM command nibbles
  localparam logic [3:0] OPC_STOP      = 4'h0;
  localparam logic [3:0] OPC_RUN_MAX   = 4'hb;
  localparam logic [3:0] OPC_COUNT     = 4'hc;
  localparam logic [3:0] OPC_XOFF      = 4'hd;
  localparam logic [3:0] OPC_LAYER     = 4'he;
  localparam logic [3:0] OPC_NEXT_LINE = 4'hf;

  // Screen limits
  localparam logic [CUR_X_W-1:0] CUR_X_MAX = {CUR_X_W{1'b1}};
  localparam logic [CUR_Y_W-1:0] CUR_Y_MAX = {CUR_Y_W{1'b1}};
  localparam logic [LEN_W-1:0]   SCREEN_W  = 9'd256;

  typedef enum logic [2:0] {
    OP_DEST,
    OP_LAYER,
    OP_SOURCE,
    OP_START,
    OP_ROM,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    KIND_SPAN,
    KIND_DONE,
    KIND_OVERRUN,
    KIND_FILL
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OP,
    PH_LAYER,
    PH_XOFF,
    PH_COUNT
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    kind_e                 kind;
    logic [COORD_W-1:0]    x_start;
    logic [COORD_W-1:0]    row;
    logic [LEN_W-1:0]      run_length;
    logic [PEN_W-1:0]      pen_value;
    logic [MASK_W-1:0]     write_mask;
    logic [END_ADDR_W-1:0] end_address;
  } result_t;

endpackage

FILE: hw/rtl/rlbd_front.sv
module rlbd_front import rlbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TUSER_W-1:0] s_user_i,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  output q_head_t               head_o,
  input  logic                  pop_i
);

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              known;
  op_e               op;
  logic              push;
  logic              pop;

  // Classify the bus command; unused codes never enter the queue.
  always_comb begin
    known = 1'b1;
    op    = OP_DEST;
    case (s_user_i)
      CMD_SET_DEST:   op = OP_DEST;
      CMD_SET_LAYER:  op = OP_LAYER;
      CMD_SET_SOURCE: op = OP_SOURCE;
      CMD_START:      op = OP_START;
      CMD_ROM_BYTE:   op = OP_ROM;
      CMD_CLEAR:      op = OP_CLEAR;
      default:        known = 1'b0;
    endcase
  end

  assign s_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push      = s_valid_i && s_ready_o && known;
  assign pop       = pop_i && (count_q != '0);

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op, value: s_data_i};
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule

FILE: hw/rtl/rlbd_back.sv
module rlbd_back import rlbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  q_head_t head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  // Configuration derived at write time.
  logic [ROM_LEN_W-1:0] limit_q;
  logic [MASK_W-1:0]    present_q, present_d;
  logic [BMP_CNT_W-1:0] bmp_n;
  logic [ROM_LEN_W-1:0] rom_len;

  // Blit state
  phase_e             phase_q, phase_d;
  logic [COORD_W-1:0] dest_x_q, dest_x_d;
  logic [COORD_W-1:0] dest_y_q, dest_y_d;
  logic [MASK_W-1:0]  layer_q, layer_d;
  logic [SRC_W-1:0]   src_q, src_d;
  logic [CUR_X_W-1:0] cur_x_q, cur_x_d;
  logic [CUR_Y_W-1:0] cur_y_q, cur_y_d;
  logic [PEN_W-1:0]   pen_q, pen_d;

  // Output register
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;

  // Per-item decode
  logic               busy;
  logic               over;
  logic [MASK_W-1:0]  mask_now;
  logic [VALUE_W-1:0] v;
  logic [7:0]         b;
  logic [3:0]         opc;
  logic [PEN_W-1:0]   byte_pen;
  logic [SRC_W-1:0]   src_inc;
  logic               res_valid;
  result_t            res;

  // Run drawing shared by short runs and counted runs
  logic               run_en;
  logic [7:0]         run_n;
  logic [PEN_W-1:0]   run_pen;
  logic [CUR_X_W:0]   run_nx;
  logic [LEN_W-1:0]   run_room;
  logic [LEN_W-1:0]   run_len;
  logic               run_vis;

  // Limit is min(rom_length, 2^ADDR_BITS); mask is the bitmaps present.
  assign rom_len = cfg_i.data[ROM_LEN_W-1:0];
  assign bmp_n   = (cfg_i.data[BMP_CNT_W-1:0] < BMP_CNT_W'(NUM_BITMAPS)) ?
                   cfg_i.data[BMP_CNT_W-1:0] : BMP_CNT_W'(NUM_BITMAPS);
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      present_d[i] = (BMP_CNT_W'(i) < bmp_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= ROM_CAP;
      present_q <= PRESENT_ALL;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_ROM_LENGTH) begin
        limit_q <= (rom_len < ROM_CAP) ? rom_len : ROM_CAP;
      end else if (cfg_i.index == CFG_BITMAP_COUNT) begin
        present_q <= present_d;
      end
    end
  end

  assign busy     = (phase_q != PH_IDLE);
  assign over     = (ROM_LEN_W'(src_q) >= limit_q);
  assign mask_now = ~layer_q & present_q;
  assign v        = head_i.item.value;
  assign b        = v[7:0];
  assign opc      = b[3:0];
  assign byte_pen = b[7:4];
  assign src_inc  = src_q + 1'b1;

  // Clipping of a run at the current cursor.
  assign run_nx   = {1'b0, cur_x_q} + (CUR_X_W + 1)'(run_n);
  assign run_room = SCREEN_W - LEN_W'(cur_x_q);
  assign run_len  = (LEN_W'(run_n) < run_room) ? LEN_W'(run_n) : run_room;
  assign run_vis  = (run_n != '0) && (cur_x_q <= CUR_X_W'(255)) &&
                    (cur_y_q <= CUR_Y_W'(255));

  // Execute the item at the head of the queue.
  always_comb begin
    phase_d   = phase_q;
    dest_x_d  = dest_x_q;
    dest_y_d  = dest_y_q;
    layer_d   = layer_q;
    src_d     = src_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    pen_d     = pen_q;
    res_valid = 1'b0;
    res       = '0;
    run_en    = 1'b0;
    run_n     = b;
    run_pen   = pen_q;

    case (head_i.item.op)
      OP_DEST: begin
        if (!busy) begin
          dest_x_d = v[7:0];
          dest_y_d = v[15:8];
        end
      end
      OP_LAYER: begin
        if (!busy) begin
          layer_d = v[7:0];
        end
      end
      OP_SOURCE: begin
        if (!busy) begin
          src_d = SRC_W'(v[ADDR_BITS-1:0]);
        end
      end
      OP_START: begin
        if (!busy) begin
          cur_x_d = CUR_X_W'(dest_x_q);
          cur_y_d = CUR_Y_W'(dest_y_q);
          if (over) begin
            res_valid       = 1'b1;
            res.kind        = KIND_OVERRUN;
            res.end_address = END_ADDR_W'(src_q);
          end else begin
            phase_d = PH_OP;
          end
        end
      end
      OP_ROM: begin
        if (busy) begin
          if (over) begin
            // The byte is not consumed and the blit ends.
            res_valid       = 1'b1;
            res.kind        = KIND_OVERRUN;
            res.end_address = END_ADDR_W'(src_q);
            phase_d         = PH_IDLE;
          end else begin
            src_d = src_inc;
            case (phase_q)
              PH_LAYER: begin
                layer_d = b;
                phase_d = PH_OP;
              end
              PH_XOFF: begin
                cur_x_d = CUR_X_W'({1'b0, dest_x_q} + {1'b0, b});
                phase_d = PH_COUNT;
              end
              PH_COUNT: begin
                run_en  = 1'b1;
                run_n   = b;
                run_pen = pen_q;
                phase_d = PH_OP;
              end
              default: begin
                if (opc == OPC_STOP) begin
                  res_valid       = 1'b1;
                  res.kind        = KIND_DONE;
                  res.end_address = END_ADDR_W'(src_inc);
                  phase_d         = PH_IDLE;
                end else if (opc <= OPC_RUN_MAX) begin
                  run_en  = 1'b1;
                  run_n   = {4'b0, opc};
                  run_pen = byte_pen;
                end else if (opc == OPC_COUNT) begin
                  pen_d   = byte_pen;
                  phase_d = PH_COUNT;
                end else if (opc == OPC_XOFF) begin
                  pen_d   = byte_pen;
                  phase_d = PH_XOFF;
                end else if (opc == OPC_LAYER) begin
                  cur_x_d = CUR_X_W'(dest_x_q);
                  phase_d = PH_LAYER;
                end else begin
                  // Next line.
                  cur_y_d = (cur_y_q < CUR_Y_MAX) ? cur_y_q + 1'b1 : CUR_Y_MAX;
                  cur_x_d = CUR_X_W'(dest_x_q);
                end
              end
            endcase
          end
        end
      end
      OP_CLEAR: begin
        res_valid      = 1'b1;
        res.kind       = KIND_FILL;
        res.x_start    = dest_x_q;
        res.row        = dest_y_q;
        res.run_length = SCREEN_W - LEN_W'(dest_x_q);
        res.pen_value  = v[7:4];
        res.write_mask = mask_now;
      end
      default: begin
      end
    endcase

    // A visible run emits its clipped span; every run moves the cursor with saturation.
    if (run_en) begin
      cur_x_d = (run_nx > (CUR_X_W + 1)'(CUR_X_MAX)) ? CUR_X_MAX : run_nx[CUR_X_W-1:0];
      if (run_vis) begin
        res_valid      = 1'b1;
        res.kind       = KIND_SPAN;
        res.x_start    = cur_x_q[COORD_W-1:0];
        res.row        = cur_y_q[COORD_W-1:0];
        res.run_length = run_len;
        res.pen_value  = run_pen;
        res.write_mask = mask_now;
      end
    end
  end

  // An item without a result retires even while the output is stalled.
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_i.valid && (!res_valid || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      dest_x_q <= '0;
      dest_y_q <= '0;
      layer_q  <= '0;
      src_q    <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      pen_q    <= '0;
    end else if (pop_o) begin
      phase_q  <= phase_d;
      dest_x_q <= dest_x_d;
      dest_y_q <= dest_y_d;
      layer_q  <= layer_d;
      src_q    <= src_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      pen_q    <= pen_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pop_o && res_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_free && pop_o && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hw/rtl/run_length_blitter_decoder_unit.sv
// Run-length blitter command decoder.
//
// Slave stream: one bus command per transfer. tuser carries the command
// (set destination, set layer, set source, start, ROM byte, clear) and
// tdata the 24-bit value. Master stream: one result per transfer, tuser
// holding the kind (span, blit done, ROM overrun, fill to end).
// Configuration: cfg_index_i selects rom_length (0) or bitmap_count (1);
// cfg_ready_o is always high, so each valid cycle is a write. Write it
// only while no command is in flight.
//
// Throughput is one command per cycle unless a result waits on a stalled
// master side. A command transfer is queued in a two-entry queue and
// executed by the back end when it reaches the head; its result is then
// registered in the output register before it transfers on the master port.
// The single executor, which updates the blit cursor and source address
// for each byte, sets that rate. Commands that produce no result retire
// even when the master side stalls; a stalled result holds the executor
// only for the next result, and the queue then fills and drops s_axis_tready_o.
// Reset returns the block to idle with all state cleared, the ROM limit
// at 2^24 bytes and all eight bitmaps present; no clearing pass is needed.
module run_length_blitter_decoder_unit import rlbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Command stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [23:0] value
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,  // [2:0] cmd
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] x_start, [15:8] row, [24:16] run_length, [28:25] pen_value,
  // [36:29] write_mask, [60:37] end_address, [63:61] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o   // [1:0] kind
);

  cfg_wr_t cfg;
  q_head_t head;
  logic    pop;
  result_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  rlbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_user_i  (s_axis_tuser_i),
    .s_data_i  (s_axis_tdata_i),
    .head_o    (head),
    .pop_i     (pop)
  );

  rlbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // Pack the result fields, lowest first.
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {3'b000, res.end_address, res.write_mask, res.pen_value,
                           res.run_length, res.row, res.x_start};

`ifndef SYNTHESIS
  // A span always covers at least one pixel and never passes the screen edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_SPAN) |->
      (res.run_length != '0 &&
       ({1'b0, res.run_length} + 10'(res.x_start)) <= 10'd256))
    else $error("span length out of range");

  // A fill covers the rest of its first row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_FILL) |->
      (res.run_length == SCREEN_W - LEN_W'(res.x_start)))
    else $error("fill length does not reach the row end");

  // Done and overrun results carry only the end address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_DONE ||
                         m_axis_tuser_o == KIND_OVERRUN)) |->
      (res.x_start == '0 && res.row == '0 && res.run_length == '0 &&
       res.pen_value == '0 && res.write_mask == '0))
    else $error("end-of-blit result with drawing fields set");

  // Nothing is retired from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty command queue");
`endif

endmodule
